[hdl/tarwm_pkg.sv]
`default_nettype none

package tarwm_pkg;

  localparam int unsigned RATE_W         = 16;
  localparam int unsigned MAG_W          = 15;
  localparam int unsigned LIMIT_W        = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned WINDOW_LEN_DEF = 8;

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = '1;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_X = 3'd0,
    CFG_HIGH_Y = 3'd1,
    CFG_HIGH_Z = 3'd2,
    CFG_LOW_X  = 3'd3,
    CFG_LOW_Y  = 3'd4,
    CFG_LOW_Z  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
    logic [MAG_W-1:0] z;
  } mag_vec_t;

  typedef struct packed {
    logic load;
    logic step;
  } mean_ctl_t;

  // Negative full scale has no 15-bit magnitude and saturates to the largest one.
  function automatic logic [MAG_W-1:0] abs_sat(input logic [RATE_W-1:0] raw);
    logic [RATE_W-1:0] neg;
    logic [MAG_W-1:0]  mag;
    neg = RATE_W'(~raw + 1'b1);
    if (!raw[RATE_W-1]) begin
      mag = raw[MAG_W-1:0];
    end else if (neg[RATE_W-1]) begin
      mag = '1;
    end else begin
      mag = neg[MAG_W-1:0];
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

[hdl/tarwm_if.sv]
`default_nettype none

interface tarwm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [tarwm_pkg::RATE_W-1:0]      rate_x;
  logic signed [tarwm_pkg::RATE_W-1:0]      rate_y;
  logic signed [tarwm_pkg::RATE_W-1:0]      rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface tarwm_out_if;
  logic                          valid;
  logic                          ready;
  logic [tarwm_pkg::MAG_W-1:0]   mean_x;
  logic [tarwm_pkg::MAG_W-1:0]   mean_y;
  logic [tarwm_pkg::MAG_W-1:0]   mean_z;
  logic                          rate_high;
  logic                          rate_low;

  modport source (output valid, output mean_x, output mean_y, output mean_z,
                  output rate_high, output rate_low, input ready);
  modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                  input rate_high, input rate_low, output ready);
endinterface

`default_nettype wire

[hdl/tarwm_cell.sv]
`default_nettype none

module tarwm_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                shift_i,
  input  wire tarwm_pkg::mag_vec_t mag_i,
  output tarwm_pkg::mag_vec_t      mag_o
);

  tarwm_pkg::mag_vec_t mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
    end else if (shift_i) begin
      mag_q <= mag_i;
    end
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

[hdl/tarwm_mean.sv]
`default_nettype none

module tarwm_mean #(
  parameter int unsigned WINDOW_LEN = tarwm_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tarwm_pkg::mean_ctl_t         ctl_i,
  input  wire logic [tarwm_pkg::MAG_W-1:0]  new_mag_i,
  input  wire logic [tarwm_pkg::MAG_W-1:0]  old_mag_i,
  output logic      [tarwm_pkg::MAG_W-1:0]  mean_o
);

  localparam int unsigned LEN_LOG = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W   = tarwm_pkg::MAG_W + LEN_LOG;
  localparam int unsigned SHIFT   = SUM_W + LEN_LOG;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  snap_q;
  logic [PROD_W-1:0] prod_q;

  // The rounded-up reciprocal is exact for every sum the window can hold.
  assign sum_d = sum_q - SUM_W'(old_mag_i) + SUM_W'(new_mag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.load) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      snap_q <= sum_d;
    end
    if (ctl_i.step) begin
      prod_q <= PROD_W'(snap_q) * PROD_W'(RECIP);
    end
  end

  assign mean_o = prod_q[SHIFT +: tarwm_pkg::MAG_W];

endmodule

`default_nettype wire

[hdl/three_axis_rate_window_monitor_core.sv]
`default_nettype none

// Three-axis rate window monitor. Each item brings one signed rate sample per
// axis; the saturated magnitudes shift into a chain of WINDOW_LEN cells that
// starts cleared, and per axis the block returns the truncated mean magnitude
// over the window with a high flag (any mean at or above its high limit) and a
// low flag (every mean at or below its low limit). It takes one item per clock
// cycle unless the sink stalls the output: one register stage updates the window
// and running sums, one holds the reciprocal multiply for the divide by the
// window length, and the output register holds the means and the limit compares.
// No clearing pass is needed after reset. Limits are to be written through the
// configuration port while no item is in flight; the block does not enforce it.
module three_axis_rate_window_monitor_core #(
  parameter int unsigned WINDOW_LEN = tarwm_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tarwm_in_if.sink                              in_if,
  tarwm_out_if.source                           out_if,
  input  wire logic                             cfg_we_i,
  input  wire logic [tarwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tarwm_pkg::LIMIT_W-1:0]    cfg_data_i
);

  logic [tarwm_pkg::LIMIT_W-1:0] high_x_q, high_y_q, high_z_q;
  logic [tarwm_pkg::LIMIT_W-1:0] low_x_q, low_y_q, low_z_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic acc, step12, step23;

  tarwm_pkg::mag_vec_t new_mag;
  tarwm_pkg::mag_vec_t chain [WINDOW_LEN+1];
  tarwm_pkg::mean_ctl_t mean_ctl;

  logic [tarwm_pkg::MAG_W-1:0] mean_x, mean_y, mean_z;
  logic [tarwm_pkg::MAG_W-1:0] mean_x_q, mean_y_q, mean_z_q;
  logic                        high_q, low_q;
  logic                        high_d, low_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_x_q <= tarwm_pkg::HIGH_LIMIT_RST;
      high_y_q <= tarwm_pkg::HIGH_LIMIT_RST;
      high_z_q <= tarwm_pkg::HIGH_LIMIT_RST;
      low_x_q  <= tarwm_pkg::LOW_LIMIT_RST;
      low_y_q  <= tarwm_pkg::LOW_LIMIT_RST;
      low_z_q  <= tarwm_pkg::LOW_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tarwm_pkg::CFG_HIGH_X: high_x_q <= cfg_data_i;
        tarwm_pkg::CFG_HIGH_Y: high_y_q <= cfg_data_i;
        tarwm_pkg::CFG_HIGH_Z: high_z_q <= cfg_data_i;
        tarwm_pkg::CFG_LOW_X:  low_x_q  <= cfg_data_i;
        tarwm_pkg::CFG_LOW_Y:  low_y_q  <= cfg_data_i;
        tarwm_pkg::CFG_LOW_Z:  low_z_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign rdy3   = !v3_q || out_if.ready;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign acc    = in_if.valid && rdy1;
  assign step12 = v1_q && rdy2;
  assign step23 = v2_q && rdy3;

  assign in_if.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= acc || (v1_q && !rdy2);
      v2_q <= step12 || (v2_q && !rdy3);
      v3_q <= step23 || (v3_q && !out_if.ready);
    end
  end

  assign new_mag.x = tarwm_pkg::abs_sat(in_if.rate_x);
  assign new_mag.y = tarwm_pkg::abs_sat(in_if.rate_y);
  assign new_mag.z = tarwm_pkg::abs_sat(in_if.rate_z);
  assign chain[0]  = new_mag;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    tarwm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (acc),
      .mag_i   (chain[k]),
      .mag_o   (chain[k+1])
    );
  end

  assign mean_ctl.load = acc;
  assign mean_ctl.step = step12;

  tarwm_mean #(.WINDOW_LEN(WINDOW_LEN)) u_mean_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mean_ctl),
    .new_mag_i (new_mag.x),
    .old_mag_i (chain[WINDOW_LEN].x),
    .mean_o    (mean_x)
  );

  tarwm_mean #(.WINDOW_LEN(WINDOW_LEN)) u_mean_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mean_ctl),
    .new_mag_i (new_mag.y),
    .old_mag_i (chain[WINDOW_LEN].y),
    .mean_o    (mean_y)
  );

  tarwm_mean #(.WINDOW_LEN(WINDOW_LEN)) u_mean_z (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mean_ctl),
    .new_mag_i (new_mag.z),
    .old_mag_i (chain[WINDOW_LEN].z),
    .mean_o    (mean_z)
  );

  assign high_d = (tarwm_pkg::LIMIT_W'(mean_x) >= high_x_q) ||
                  (tarwm_pkg::LIMIT_W'(mean_y) >= high_y_q) ||
                  (tarwm_pkg::LIMIT_W'(mean_z) >= high_z_q);
  assign low_d  = (tarwm_pkg::LIMIT_W'(mean_x) <= low_x_q) &&
                  (tarwm_pkg::LIMIT_W'(mean_y) <= low_y_q) &&
                  (tarwm_pkg::LIMIT_W'(mean_z) <= low_z_q);

  always_ff @(posedge clk_i) begin
    if (step23) begin
      mean_x_q <= mean_x;
      mean_y_q <= mean_y;
      mean_z_q <= mean_z;
      high_q   <= high_d;
      low_q    <= low_d;
    end
  end

  assign out_if.valid     = v3_q;
  assign out_if.mean_x    = mean_x_q;
  assign out_if.mean_y    = mean_y_q;
  assign out_if.mean_z    = mean_z_q;
  assign out_if.rate_high = high_q;
  assign out_if.rate_low  = low_q;

endmodule

`default_nettype wire

[hdl/tarwm_checker.sv]
`default_nettype none

module tarwm_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [tarwm_pkg::MAG_W-1:0]  mean_x_i,
  input wire logic [tarwm_pkg::MAG_W-1:0]  mean_y_i,
  input wire logic [tarwm_pkg::MAG_W-1:0]  mean_z_i,
  input wire logic                         rate_high_i,
  input wire logic                         rate_low_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(mean_x_i) && $stable(mean_y_i) && $stable(mean_z_i) &&
      $stable(rate_high_i) && $stable(rate_low_i))
    else $error("result changed while stalled");

  // An accepted item reaches the output through the pipeline stages if the sink keeps taking items.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted item did not reach the output");

endmodule

bind three_axis_rate_window_monitor_core tarwm_checker u_tarwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .mean_x_i    (out_if.mean_x),
  .mean_y_i    (out_if.mean_y),
  .mean_z_i    (out_if.mean_z),
  .rate_high_i (out_if.rate_high),
  .rate_low_i  (out_if.rate_low)
);

`default_nettype wire
